// ----- hdl/eip_pkg.sv -----
// Shared types, constants and table builders for the eased interpolator.
// Used by eip_div, eip_curve, eip_blend and eased_interpolator.
// No dependencies.
package eip_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int TIME_WIDTH  = 24;
    localparam int FRAC_BITS   = 16;
    localparam int TABLE_DEPTH = 256;

    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int KIND_W      = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = (TIME_WIDTH > VALUE_WIDTH) ? TIME_WIDTH : VALUE_WIDTH;
    localparam int RATE_W      = FRAC_BITS + 4;
    localparam int DIV_STAGES  = FRAC_BITS + 1;

    localparam int ONE_Q = 1 << FRAC_BITS;

    localparam logic [CFG_INDEX_W-1:0] REG_START_VALUE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_VALUE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_TIME  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_TIME    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CURVE_KIND  = 3'd4;

    localparam logic [KIND_W-1:0] CURVE_LINEAR  = 4'd0;
    localparam logic [KIND_W-1:0] CURVE_QUAD    = 4'd1;
    localparam logic [KIND_W-1:0] CURVE_CUBIC   = 4'd2;
    localparam logic [KIND_W-1:0] CURVE_QUART   = 4'd3;
    localparam logic [KIND_W-1:0] CURVE_QUINT   = 4'd4;
    localparam logic [KIND_W-1:0] CURVE_EXPO    = 4'd5;
    localparam logic [KIND_W-1:0] CURVE_BACK    = 4'd6;
    localparam logic [KIND_W-1:0] CURVE_ELASTIC = 4'd7;
    localparam logic [KIND_W-1:0] CURVE_SINE    = 4'd8;

    localparam longint BACK_A_L    = ((longint'(270158) << FRAC_BITS) + 50000) / 100000;
    localparam longint BACK_B_L    = ((longint'(170158) << FRAC_BITS) + 50000) / 100000;
    localparam longint ELASTIC_C_L = ((longint'(11502) << FRAC_BITS) + 500) / 1000;

    localparam logic [FRAC_BITS+1:0] BACK_A    = (FRAC_BITS+2)'(BACK_A_L);
    localparam logic [FRAC_BITS+1:0] BACK_B    = (FRAC_BITS+2)'(BACK_B_L);
    localparam logic [FRAC_BITS+4:0] ELASTIC_C = (FRAC_BITS+5)'(ELASTIC_C_L);

    localparam logic [63:0] Q30         = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] ROUND_Q30   = 64'd1 << (29 - FRAC_BITS);

    typedef enum logic [1:0] {
        SPAN_START,
        SPAN_END,
        SPAN_MID
    } span_t;

    typedef struct packed {
        span_t                span;
        logic [FRAC_BITS-1:0] t;
    } frac_item_t;

    typedef struct packed {
        span_t                    span;
        logic signed [RATE_W-1:0] rate;
    } rate_item_t;

    // unsigned quotient by shift and subtract, for table building only
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        int          b;
        rem = '0;
        q   = '0;
        for (b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^(-i/TABLE_DEPTH) in Q.FRAC_BITS
    function automatic logic [FRAC_BITS:0] pow2_entry(int i);
        logic [63:0]        y;
        logic [63:0]        term;
        logic signed [63:0] sum;
        int                 k;
        y    = (LN2_Q30 * 64'(i)) >> IDX_W;
        sum  = $signed(Q30);
        term = Q30;
        for (k = 1; k <= 16; k++)
        begin
            term = udiv64((term * y) >> 30, 64'(k));
            if (k[0])
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        return (FRAC_BITS+1)'((64'(sum) + ROUND_Q30) >> (30 - FRAC_BITS));
    endfunction

    // sin(2*pi*i/TABLE_DEPTH) in signed Q.FRAC_BITS
    function automatic logic signed [FRAC_BITS+1:0] sine_entry(int i);
        logic [63:0]               x;
        logic [63:0]               term;
        logic signed [63:0]        sum;
        logic                      neg;
        logic signed [FRAC_BITS+1:0] r;
        int                        k;
        x   = (TWO_PI_Q30 * 64'(i)) >> IDX_W;
        neg = 1'b0;
        if (x >= PI_Q30)
        begin
            x   = x - PI_Q30;
            neg = 1'b1;
        end
        if (x > HALF_PI_Q30)
            x = PI_Q30 - x;
        sum  = $signed(x);
        term = x;
        for (k = 1; k <= 10; k++)
        begin
            term = udiv64((((term * x) >> 30) * x) >> 30,
                          64'(2 * k) * 64'(2 * k + 1));
            if (k[0])
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        r = (FRAC_BITS+2)'((64'(sum) + ROUND_Q30) >> (30 - FRAC_BITS));
        return neg ? -r : r;
    endfunction

endpackage

// ----- hdl/eip_div.sv -----
// Span classification and pipelined restoring divider, one quotient bit per stage.
// Produces the Q0.FRAC_BITS fraction of the time sample. Depends on eip_pkg.
module eip_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [eip_pkg::TIME_WIDTH-1:0] now_time,
    input  logic [eip_pkg::TIME_WIDTH-1:0] start_time,
    input  logic [eip_pkg::TIME_WIDTH-1:0] end_time,
    output logic                           out_valid,
    input  logic                           out_ready,
    output eip_pkg::frac_item_t            out_item
);
    import eip_pkg::*;

    localparam int N = DIV_STAGES;

    logic [N-1:0]          v_reg;
    logic [N:0]            rdy;
    logic [N-1:0]          feed;
    logic [TIME_WIDTH-1:0] rem_reg  [N];
    logic [TIME_WIDTH-1:0] den_reg  [N];
    logic [FRAC_BITS-1:0]  q_reg    [N];
    span_t                 span_reg [N];
    logic [TIME_WIDTH-1:0] rem_next [N];
    logic [TIME_WIDTH-1:0] den_next [N];
    logic [FRAC_BITS-1:0]  q_next   [N];
    span_t                 span_next [N];

    assign rdy[N]   = out_ready;
    assign feed     = {v_reg[N-2:0], in_valid};
    assign in_ready = rdy[0];

    for (genvar k = 0; k < N; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    always_comb
    begin
        rem_next[0] = now_time - start_time;
        den_next[0] = end_time - start_time;
        q_next[0]   = '0;
        if (now_time <= start_time)
            span_next[0] = SPAN_START;
        else if (now_time >= end_time)
            span_next[0] = SPAN_END;
        else
            span_next[0] = SPAN_MID;
    end

    for (genvar k = 1; k < N; k++)
    begin : g_bit
        logic [TIME_WIDTH:0] shifted;
        logic                take;
        assign shifted      = {rem_reg[k-1], 1'b0};
        assign take         = shifted >= {1'b0, den_reg[k-1]};
        assign rem_next[k]  = take ? TIME_WIDTH'(shifted - {1'b0, den_reg[k-1]})
                                   : shifted[TIME_WIDTH-1:0];
        assign den_next[k]  = den_reg[k-1];
        assign q_next[k]    = {q_reg[k-1][FRAC_BITS-2:0], take};
        assign span_next[k] = span_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= feed[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N; k++)
        begin
            if (rdy[k] && feed[k])
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_next[k];
                q_reg[k]    <= q_next[k];
                span_reg[k] <= span_next[k];
            end
        end
    end

    assign out_valid     = v_reg[N-1];
    assign out_item.span = span_reg[N-1];
    assign out_item.t    = q_reg[N-1];

endmodule

// ----- hdl/eip_curve.sv -----
// Four-stage ease-in curve unit: powers, back, expo, elastic and sine rates.
// Holds the 2^-x and sine tables. Depends on eip_pkg.
module eip_curve (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  eip_pkg::frac_item_t        in_item,
    input  logic [eip_pkg::KIND_W-1:0] curve_kind,
    output logic                       out_valid,
    input  logic                       out_ready,
    output eip_pkg::rate_item_t        out_item
);
    import eip_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int E_W  = F + 5;
    localparam int N    = 4;

    logic [F:0]          pow2_rom [TABLE_DEPTH];
    logic signed [F+1:0] sine_rom [TABLE_DEPTH];

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_rom
        localparam logic [F:0]          P = pow2_entry(i);
        localparam logic signed [F+1:0] S = sine_entry(i);
        assign pow2_rom[i] = P;
        assign sine_rom[i] = S;
    end

    logic [N-1:0] v_reg;
    logic [N:0]   rdy;
    logic [N-1:0] feed;

    assign rdy[N]   = out_ready;
    assign feed     = {v_reg[N-2:0], in_valid};
    assign in_ready = rdy[0];

    for (genvar k = 0; k < N; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    // stage 1
    logic [F-1:0]     c1_t_reg, c1_m1_reg, c1_m1_next;
    logic [F+1:0]     c1_at_reg, c1_at_next;
    logic [IDX_W-1:0] c1_pidx_reg, c1_pidx_next, c1_sidx_reg, c1_sidx_next;
    logic [4:0]       c1_pn_reg, c1_pn_next;
    logic             c1_tzero_reg;
    span_t            c1_span_reg;
    logic [2*F-1:0]   sq_prod;
    logic [2*F+1:0]   at_prod;
    logic [F:0]       omt;
    logic [E_W-1:0]   e_val;
    logic [F:0]       eph;
    logic [F+1:0]     sph;

    always_comb
    begin
        sq_prod      = (2*F)'(in_item.t) * (2*F)'(in_item.t);
        c1_m1_next   = sq_prod[2*F-1:F];
        at_prod      = (2*F+2)'(BACK_A) * (2*F+2)'(in_item.t);
        c1_at_next   = at_prod[2*F+1:F];
        omt          = (F+1)'(ONE_Q) - {1'b0, in_item.t};
        e_val        = E_W'(omt) * E_W'(10);
        c1_pidx_next = e_val[F-1 -: IDX_W];
        c1_pn_next   = e_val[E_W-1:F];
        eph          = (F+1)'(in_item.t) * (F+1)'(9) - (F+1)'(ELASTIC_C);
        sph          = (F+2)'(in_item.t) + (F+2)'(ONE_Q);
        c1_sidx_next = (curve_kind == CURVE_ELASTIC) ? eph[F -: IDX_W] : sph[F+1 -: IDX_W];
    end

    // stage 2
    logic [F-1:0]        c2_t_reg, c2_m1_reg, c2_m2_reg, c2_m2_next;
    logic signed [F+2:0] c2_c_reg, c2_c_next;
    logic [F:0]          c2_pv_reg, c2_pv_next;
    logic signed [F+1:0] c2_sv_reg;
    logic                c2_tzero_reg;
    span_t               c2_span_reg;
    logic [2*F-1:0]      m2_prod;

    always_comb
    begin
        m2_prod    = (2*F)'(c1_m1_reg) * (2*F)'(c1_t_reg);
        c2_m2_next = m2_prod[2*F-1:F];
        c2_c_next  = $signed({1'b0, c1_at_reg}) - $signed({1'b0, BACK_B});
        c2_pv_next = pow2_rom[c1_pidx_reg] >> c1_pn_reg;
    end

    // stage 3
    logic [F-1:0]               c3_t_reg, c3_m1_reg, c3_m2_reg, c3_m3_reg, c3_m3_next;
    logic signed [RATE_W-1:0]   c3_back_reg, c3_back_next, c3_el_reg, c3_el_next;
    logic [F:0]                 c3_pv_reg;
    logic signed [F+1:0]        c3_sv_reg;
    logic                       c3_tzero_reg;
    span_t                      c3_span_reg;
    logic [2*F-1:0]             m3_prod;
    logic [F+1:0]               cmag;
    logic [2*F+1:0]             bk_prod;
    logic [F+1:0]               smag;
    logic [2*F+2:0]             el_prod;

    always_comb
    begin
        m3_prod      = (2*F)'(c2_m2_reg) * (2*F)'(c2_t_reg);
        c3_m3_next   = m3_prod[2*F-1:F];
        cmag         = c2_c_reg[F+2] ? (F+2)'(-c2_c_reg) : (F+2)'(c2_c_reg);
        bk_prod      = (2*F+2)'(c2_m1_reg) * (2*F+2)'(cmag);
        c3_back_next = c2_c_reg[F+2] ? -RATE_W'(bk_prod[2*F+1:F])
                                     :  RATE_W'(bk_prod[2*F+1:F]);
        smag         = c2_sv_reg[F+1] ? (F+2)'(-c2_sv_reg) : (F+2)'(c2_sv_reg);
        el_prod      = (2*F+3)'(c2_pv_reg) * (2*F+3)'(smag);
        c3_el_next   = c2_sv_reg[F+1] ?  RATE_W'(el_prod[2*F+2:F])
                                      : -RATE_W'(el_prod[2*F+2:F]);
    end

    // stage 4
    logic signed [RATE_W-1:0] c4_rate_reg, c4_rate_next;
    span_t                    c4_span_reg;
    logic [2*F-1:0]           m4_prod;

    always_comb
    begin
        m4_prod = (2*F)'(c3_m3_reg) * (2*F)'(c3_t_reg);
        case (curve_kind)
            CURVE_QUAD:    c4_rate_next = RATE_W'(c3_m1_reg);
            CURVE_CUBIC:   c4_rate_next = RATE_W'(c3_m2_reg);
            CURVE_QUART:   c4_rate_next = RATE_W'(c3_m3_reg);
            CURVE_QUINT:   c4_rate_next = RATE_W'(m4_prod[2*F-1:F]);
            CURVE_EXPO:    c4_rate_next = c3_tzero_reg ? '0 : RATE_W'(c3_pv_reg);
            CURVE_BACK:    c4_rate_next = c3_back_reg;
            CURVE_ELASTIC: c4_rate_next = c3_el_reg;
            CURVE_SINE:    c4_rate_next = RATE_W'(ONE_Q) - RATE_W'(c3_sv_reg);
            default:       c4_rate_next = RATE_W'(c3_t_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= feed[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && feed[0])
        begin
            c1_t_reg     <= in_item.t;
            c1_span_reg  <= in_item.span;
            c1_m1_reg    <= c1_m1_next;
            c1_at_reg    <= c1_at_next;
            c1_pidx_reg  <= c1_pidx_next;
            c1_pn_reg    <= c1_pn_next;
            c1_sidx_reg  <= c1_sidx_next;
            c1_tzero_reg <= (in_item.t == '0);
        end
        if (rdy[1] && feed[1])
        begin
            c2_t_reg     <= c1_t_reg;
            c2_span_reg  <= c1_span_reg;
            c2_m1_reg    <= c1_m1_reg;
            c2_m2_reg    <= c2_m2_next;
            c2_c_reg     <= c2_c_next;
            c2_pv_reg    <= c2_pv_next;
            c2_sv_reg    <= sine_rom[c1_sidx_reg];
            c2_tzero_reg <= c1_tzero_reg;
        end
        if (rdy[2] && feed[2])
        begin
            c3_t_reg     <= c2_t_reg;
            c3_span_reg  <= c2_span_reg;
            c3_m1_reg    <= c2_m1_reg;
            c3_m2_reg    <= c2_m2_reg;
            c3_m3_reg    <= c3_m3_next;
            c3_back_reg  <= c3_back_next;
            c3_el_reg    <= c3_el_next;
            c3_pv_reg    <= c2_pv_reg;
            c3_sv_reg    <= c2_sv_reg;
            c3_tzero_reg <= c2_tzero_reg;
        end
        if (rdy[3] && feed[3])
        begin
            c4_rate_reg <= c4_rate_next;
            c4_span_reg <= c3_span_reg;
        end
    end

    assign out_valid     = v_reg[N-1];
    assign out_item.span = c4_span_reg;
    assign out_item.rate = c4_rate_reg;

endmodule

// ----- hdl/eip_blend.sv -----
// Three-stage blend of start and end values by the eased rate, with
// truncation toward zero and saturation. Depends on eip_pkg.
module eip_blend (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  eip_pkg::rate_item_t                    in_item,
    input  logic signed [eip_pkg::VALUE_WIDTH-1:0] start_value,
    input  logic signed [eip_pkg::VALUE_WIDTH-1:0] end_value,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [eip_pkg::VALUE_WIDTH-1:0] eased_value
);
    import eip_pkg::*;

    localparam int V      = VALUE_WIDTH;
    localparam int PROD_W = VALUE_WIDTH + RATE_W + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam int N      = 3;

    localparam logic [ACC_W-1:0] MAG_POS = ACC_W'((64'd1 << (V - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] MAG_NEG = ACC_W'(64'd1 << (V - 1));
    localparam logic signed [V-1:0] VAL_MAX = {1'b0, {(V-1){1'b1}}};
    localparam logic signed [V-1:0] VAL_MIN = {1'b1, {(V-1){1'b0}}};

    logic [N-1:0] v_reg;
    logic [N:0]   rdy;
    logic [N-1:0] feed;

    assign rdy[N]   = out_ready;
    assign feed     = {v_reg[N-2:0], in_valid};
    assign in_ready = rdy[0];

    for (genvar k = 0; k < N; k++)
    begin : g_rdy
        assign rdy[k] = !v_reg[k] || rdy[k+1];
    end

    logic signed [RATE_W:0]   om;
    logic signed [PROD_W-1:0] b1_p1_reg, b1_p2_reg, b1_p1_next, b1_p2_next;
    span_t                    b1_span_reg;
    logic signed [ACC_W-1:0]  b2_acc_reg;
    span_t                    b2_span_reg;
    logic signed [V-1:0]      b3_val_reg, b3_val_next;
    logic [ACC_W-1:0]         amag;
    logic [ACC_W-1:0]         shmag;

    always_comb
    begin
        om         = (RATE_W+1)'(ONE_Q) - (RATE_W+1)'(in_item.rate);
        b1_p1_next = PROD_W'(start_value) * PROD_W'(om);
        b1_p2_next = PROD_W'(end_value) * PROD_W'(in_item.rate);
    end

    always_comb
    begin
        amag  = b2_acc_reg[ACC_W-1] ? ACC_W'(-b2_acc_reg) : ACC_W'(b2_acc_reg);
        shmag = amag >> FRAC_BITS;
        case (b2_span_reg)
            SPAN_START: b3_val_next = start_value;
            SPAN_END:   b3_val_next = end_value;
            default:
            begin
                if (b2_acc_reg[ACC_W-1])
                    b3_val_next = (shmag > MAG_NEG) ? VAL_MIN : -V'(shmag);
                else
                    b3_val_next = (shmag > MAG_POS) ? VAL_MAX : V'(shmag);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < N; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= feed[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && feed[0])
        begin
            b1_p1_reg   <= b1_p1_next;
            b1_p2_reg   <= b1_p2_next;
            b1_span_reg <= in_item.span;
        end
        if (rdy[1] && feed[1])
        begin
            b2_acc_reg  <= ACC_W'(b1_p1_reg) + ACC_W'(b1_p2_reg);
            b2_span_reg <= b1_span_reg;
        end
        if (rdy[2] && feed[2])
            b3_val_reg <= b3_val_next;
    end

    assign out_valid   = v_reg[N-1];
    assign eased_value = b3_val_reg;

endmodule

// ----- hdl/eased_interpolator.sv -----
// Eased interpolator top level: configuration registers, divider, curve and blend.
// Depends on eip_pkg, eip_div, eip_curve and eip_blend.
//
// Usage:
//   Configuration: write register cfg_index with cfg_data on cfg_valid; cfg_ready
//   is always high. Index 0 start_value, 1 end_value, 2 start_time, 3 end_time,
//   4 curve_kind; other indexes are dropped. Write only while no item is in flight.
//   Input: one now_time item per in_valid/in_ready handshake.
//   Output: one eased_value item per input item, in order, on out_valid/out_ready.
//   Pipeline: 1 classify stage, 16 divider bit stages, 4 curve stages and 3 blend
//   stages. Throughput: one item per cycle while out_ready is high.
//   Every stage holds its own valid bit; an empty stage takes a new item even
//   while the output is stalled, so in_ready drops only once every stage is full
//   and out_ready is low. Nothing is lost or repeated across a stall.
//   Reset: all stages empty; start_value 0, end_value 0, start_time 0,
//   end_time 1, curve_kind linear.
module eased_interpolator (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [eip_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  logic [eip_pkg::CFG_DATA_W-1:0]           cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [eip_pkg::TIME_WIDTH-1:0]           now_time,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [eip_pkg::VALUE_WIDTH-1:0]   eased_value
);
    import eip_pkg::*;

    logic signed [VALUE_WIDTH-1:0] start_value_reg;
    logic signed [VALUE_WIDTH-1:0] end_value_reg;
    logic [TIME_WIDTH-1:0]         start_time_reg;
    logic [TIME_WIDTH-1:0]         end_time_reg;
    logic [KIND_W-1:0]             curve_kind_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_value_reg <= '0;
            end_value_reg   <= '0;
            start_time_reg  <= '0;
            end_time_reg    <= TIME_WIDTH'(1);
            curve_kind_reg  <= CURVE_LINEAR;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_START_VALUE: start_value_reg <= cfg_data[VALUE_WIDTH-1:0];
                REG_END_VALUE:   end_value_reg   <= cfg_data[VALUE_WIDTH-1:0];
                REG_START_TIME:  start_time_reg  <= cfg_data[TIME_WIDTH-1:0];
                REG_END_TIME:    end_time_reg    <= cfg_data[TIME_WIDTH-1:0];
                REG_CURVE_KIND:  curve_kind_reg  <= cfg_data[KIND_W-1:0];
                default:         ;
            endcase
        end
    end

    logic       div_valid, div_ready;
    frac_item_t div_item;
    logic       rate_valid, rate_ready;
    rate_item_t rate_item;

    eip_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .now_time   (now_time),
        .start_time (start_time_reg),
        .end_time   (end_time_reg),
        .out_valid  (div_valid),
        .out_ready  (div_ready),
        .out_item   (div_item)
    );

    eip_curve u_curve (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ready   (div_ready),
        .in_item    (div_item),
        .curve_kind (curve_kind_reg),
        .out_valid  (rate_valid),
        .out_ready  (rate_ready),
        .out_item   (rate_item)
    );

    eip_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (rate_valid),
        .in_ready    (rate_ready),
        .in_item     (rate_item),
        .start_value (start_value_reg),
        .end_value   (end_value_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .eased_value (eased_value)
    );

    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while output side can move");

    a_power_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && rate_item.span == SPAN_MID && curve_kind_reg <= CURVE_QUINT
        |-> rate_item.rate >= 0 && rate_item.rate < RATE_W'(ONE_Q))
        else $error("power curve rate outside unit range");

    a_expo_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        rate_valid && rate_item.span == SPAN_MID && curve_kind_reg == CURVE_EXPO
        |-> rate_item.rate >= 0 && rate_item.rate <= RATE_W'(ONE_Q))
        else $error("expo curve rate outside unit range");

endmodule

// ----- bench/eased_interpolator_tb.sv -----
// Testbench for eased_interpolator: random and directed time samples under many
// register settings, checked against an in-bench fixed-point predictor.
// Depends on eip_pkg and the eased_interpolator RTL.
`timescale 1ns / 1ps

module eased_interpolator_tb;
    import eip_pkg::*;

    localparam int  SETTLE_CYCLES = 40;
    localparam int  CYCLE_LIMIT   = 1000000;
    localparam int  TMAX          = (1 << TIME_WIDTH) - 1;

    typedef struct {
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
    } reg_write_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_INDEX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [TIME_WIDTH-1:0]          now_time = '0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [VALUE_WIDTH-1:0]  eased_value;

    logic [TIME_WIDTH-1:0]          time_items[$];
    reg_write_t                     reg_writes[$];
    logic signed [VALUE_WIDTH-1:0]  expected_values[$];

    logic signed [VALUE_WIDTH-1:0]  m_start_value = 0;
    logic signed [VALUE_WIDTH-1:0]  m_end_value = 0;
    logic [TIME_WIDTH-1:0]          m_start_time = 0;
    logic [TIME_WIDTH-1:0]          m_end_time = 1;
    logic [KIND_W-1:0]              m_curve = CURVE_LINEAR;

    longint                         pow2_tab[TABLE_DEPTH];
    longint                         sine_tab[TABLE_DEPTH];

    int                             mismatches = 0;
    int                             cycles = 0;
    int                             in_gap = 0;
    int                             out_gap = 0;
    bit                             steady = 0;

    eased_interpolator DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .now_time(now_time),
        .out_valid(out_valid), .out_ready(out_ready), .eased_value(eased_value)
    );

    always #5 clk = ~clk;

    function automatic longint exp_neg_q16(int i);
        bit [63:0] y;
        bit [63:0] term;
        longint    acc;
        y    = (64'd744261118 * 64'(i)) / TABLE_DEPTH;
        acc  = longint'(1) << 30;
        term = 64'd1 << 30;
        for (int k = 1; k <= 16; k++)
        begin
            term = ((term * y) >> 30) / 64'(k);
            acc  = (k % 2) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return (acc + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    function automatic longint sin_q16(int i);
        bit [63:0] x;
        bit [63:0] term;
        longint    acc;
        bit        neg;
        x   = (64'd6746518852 * 64'(i)) / TABLE_DEPTH;
        neg = 0;
        if (x >= 64'd3373259426)
        begin
            x   = x - 64'd3373259426;
            neg = 1;
        end
        if (x > 64'd1686629713)
            x = 64'd3373259426 - x;
        acc  = longint'(x);
        term = x;
        for (int k = 1; k <= 10; k++)
        begin
            term = ((((term * x) >> 30) * x) >> 30) / (64'(2 * k) * 64'(2 * k + 1));
            acc  = (k % 2) ? acc - longint'(term) : acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        return neg ? -acc : acc;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint m;
        m = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >>> FRAC_BITS;
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    function automatic longint decay_part(longint t);
        longint e;
        longint n;
        longint p;
        e = 10 * (ONE_Q - t);
        n = e >>> FRAC_BITS;
        p = pow2_tab[((e & (ONE_Q - 1)) * TABLE_DEPTH) >>> FRAC_BITS];
        return (n >= 63) ? 0 : (p >>> n);
    endfunction

    function automatic longint ease_rate(longint t);
        longint r;
        longint ph;
        case (m_curve)
            CURVE_QUAD:    r = (t * t) >>> FRAC_BITS;
            CURVE_CUBIC:   r = (((t * t) >>> FRAC_BITS) * t) >>> FRAC_BITS;
            CURVE_QUART:   r = (((((t * t) >>> FRAC_BITS) * t) >>> FRAC_BITS) * t) >>> FRAC_BITS;
            CURVE_QUINT:
            begin
                r = (((t * t) >>> FRAC_BITS) * t) >>> FRAC_BITS;
                r = (((r * t) >>> FRAC_BITS) * t) >>> FRAC_BITS;
            end
            CURVE_EXPO:    r = (t == 0) ? 0 : decay_part(t);
            CURVE_BACK:    r = fx_mul((t * t) >>> FRAC_BITS, fx_mul(BACK_A_L, t) - BACK_B_L);
            CURVE_ELASTIC:
            begin
                ph = (9 * t - ELASTIC_C_L) & ((longint'(1) << (FRAC_BITS + 1)) - 1);
                r  = -fx_mul(decay_part(t), sine_tab[(ph * TABLE_DEPTH) >>> (FRAC_BITS + 1)]);
            end
            CURVE_SINE:
            begin
                ph = (t + ONE_Q) & ((longint'(1) << (FRAC_BITS + 2)) - 1);
                r  = ONE_Q - sine_tab[(ph * TABLE_DEPTH) >>> (FRAC_BITS + 2)];
            end
            default:       r = t;
        endcase
        return r;
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] ease_value(logic [TIME_WIDTH-1:0] now);
        longint t;
        longint rate;
        longint acc;
        longint res;
        if (now <= m_start_time)
            return m_start_value;
        if (now >= m_end_time)
            return m_end_value;
        t    = (longint'(now - m_start_time) << FRAC_BITS) / longint'(m_end_time - m_start_time);
        rate = ease_rate(t);
        acc  = longint'(m_start_value) * (ONE_Q - rate) + longint'(m_end_value) * rate;
        res  = (acc < 0) ? -((-acc) >>> FRAC_BITS) : (acc >>> FRAC_BITS);
        if (res < -(longint'(1) << (VALUE_WIDTH - 1)))
            res = -(longint'(1) << (VALUE_WIDTH - 1));
        if (res > (longint'(1) << (VALUE_WIDTH - 1)) - 1)
            res = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
        return VALUE_WIDTH'(res);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_START_VALUE: m_start_value <= cfg_data[VALUE_WIDTH-1:0];
                    REG_END_VALUE:   m_end_value <= cfg_data[VALUE_WIDTH-1:0];
                    REG_START_TIME:  m_start_time <= cfg_data[TIME_WIDTH-1:0];
                    REG_END_TIME:    m_end_time <= cfg_data[TIME_WIDTH-1:0];
                    REG_CURVE_KIND:  m_curve <= cfg_data[KIND_W-1:0];
                    default:         ;
                endcase
                void'(reg_writes.pop_front());
            end
            if ((!cfg_valid || cfg_ready) && reg_writes.size() > 0)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= reg_writes[0].idx;
                cfg_data  <= reg_writes[0].data;
            end
            else if (cfg_valid && cfg_ready)
                cfg_valid <= 1'b0;

            if (in_valid && in_ready)
            begin
                expected_values.push_back(ease_value(now_time));
                void'(time_items.pop_front());
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (time_items.size() > 0)
                begin
                    in_valid <= 1'b1;
                    now_time <= time_items[0];
                    in_gap   <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_values.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected item: got %0d", eased_value);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    if (eased_value !== expected_values[0])
                    begin
                        if (mismatches < 10)
                            $display("eased_value: expected %0d got %0d",
                                     expected_values[0], eased_value);
                        mismatches <= mismatches + 1;
                    end
                    void'(expected_values.pop_front());
                end
            end
            if (out_gap > 0)
            begin
                out_gap   <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_gap   <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("eased_interpolator: mismatch");
            $finish;
        end
    end

    task automatic drain();
        while (time_items.size() != 0 || in_valid || expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(int sv, int ev, int st, int et, int kind);
        drain();
        reg_writes.push_back('{REG_START_VALUE, CFG_DATA_W'(sv) ^ (CFG_DATA_W'($urandom) << VALUE_WIDTH)});
        reg_writes.push_back('{REG_END_VALUE, CFG_DATA_W'(ev) ^ (CFG_DATA_W'($urandom) << VALUE_WIDTH)});
        reg_writes.push_back('{REG_START_TIME, CFG_DATA_W'(st)});
        reg_writes.push_back('{REG_END_TIME, CFG_DATA_W'(et)});
        reg_writes.push_back('{REG_CURVE_KIND, CFG_DATA_W'(kind)});
        if ($urandom_range(0, 3) == 0)
            reg_writes.push_back('{CFG_INDEX_W'($urandom_range(5, 7)), CFG_DATA_W'($urandom)});
        while (reg_writes.size() != 0 || cfg_valid)
            @(posedge clk);
    endtask

    function automatic int pick_value();
        case ($urandom_range(0, 5))
            0:       return -32768;
            1:       return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic logic [TIME_WIDTH-1:0] pick_time(int st, int et);
        longint v;
        if (et <= st || $urandom_range(0, 9) < 2)
            return TIME_WIDTH'($urandom);
        v = longint'(st) - 2 + longint'($urandom_range(0, et - st + 4));
        if (v < 0)
            v = 0;
        if (v > TMAX)
            v = TMAX;
        return TIME_WIDTH'(v);
    endfunction

    initial
    begin
        int st;
        int et;
        int span;
        int kind;
        int n;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            pow2_tab[i] = exp_neg_q16(i);
            sine_tab[i] = sin_q16(i);
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        time_items = '{0, 1, 2, TMAX};
        program_regs(-32768, 32767, 0, TMAX, CURVE_LINEAR);
        time_items = '{0, 1, 24'h800000, TMAX - 1, TMAX};
        program_regs(32767, -32768, 100, 100, CURVE_BACK);
        time_items = '{99, 100, 101};
        program_regs(100, -100, TMAX, 5, CURVE_SINE);
        time_items = '{0, TMAX - 1, TMAX};

        for (int ph = 0; ph < 30; ph++)
        begin
            case ($urandom_range(0, 7))
                0:       st = 0;
                1:       st = TMAX - $urandom_range(0, 50);
                default: st = $urandom_range(0, TMAX);
            endcase
            span = ($urandom_range(0, 2) == 0) ? $urandom_range(1, TMAX) : $urandom_range(1, 400);
            if ($urandom_range(0, 9) == 0)
                et = $urandom_range(0, st);
            else
                et = (longint'(st) + span > TMAX) ? TMAX : st + span;
            kind = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : ph % 9;
            program_regs(pick_value(), pick_value(), st, et, kind);
            steady = ($urandom_range(0, 3) == 0);
            n = $urandom_range(35, 65);
            for (int k = 0; k < n; k++)
            begin
                time_items.push_back(pick_time(st, et));
                if (ph == 0 && k == n / 2)
                    drain();
            end
        end

        drain();
        if (mismatches == 0)
            $display("eased_interpolator: match");
        else
            $display("eased_interpolator: mismatch");
        $finish;
    end
endmodule
